[rtl/htc_pkg.sv]
`default_nettype none
package htc_pkg;

  // Queue depth between the byte classifier and the grammar engine.
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [2:0] KEYWORD_LEN = 3'd7;

  // One classified header byte as it travels from front to back.
  typedef struct packed {
    logic       tok;
    logic       blank;
    logic       comma;
    logic       semi;
    logic       equals;
    logic       dquote;
    logic       bslash;
    logic       zero;
    logic [7:0] lower;
    logic       final_byte;
  } item_t;

  // Letters of "chunked", indexed by match position.
  function automatic logic [7:0] keyword_char(input logic [2:0] pos);
    logic [7:0] ch;
    case (pos)
      3'd0: ch = 8'h63;
      3'd1: ch = 8'h68;
      3'd2: ch = 8'h75;
      3'd3: ch = 8'h6E;
      3'd4: ch = 8'h6B;
      3'd5: ch = 8'h65;
      3'd6: ch = 8'h64;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage
`default_nettype wire

[rtl/htc_front.sv]
`default_nettype none
module htc_front (
  input  wire logic          [7:0] value_byte,
  input  wire logic                final_byte,
  output htc_pkg::item_t           item
);

  logic is_sep;
  logic is_print;

  // RFC separators: ( ) < > @ , ; : \ " / [ ] ? = { }
  always_comb begin
    case (value_byte)
      8'h28, 8'h29, 8'h3C, 8'h3E, 8'h40, 8'h2C, 8'h3B, 8'h3A, 8'h5C,
      8'h22, 8'h2F, 8'h5B, 8'h5D, 8'h3F, 8'h3D, 8'h7B, 8'h7D: is_sep = 1'b1;
      default: is_sep = 1'b0;
    endcase
  end

  assign is_print = (value_byte >= 8'h21) && (value_byte <= 8'h7E);

  always_comb begin
    item.tok        = is_print && !is_sep;
    item.blank      = (value_byte == 8'h20) || (value_byte == 8'h09);
    item.comma      = value_byte == 8'h2C;
    item.semi       = value_byte == 8'h3B;
    item.equals     = value_byte == 8'h3D;
    item.dquote     = value_byte == 8'h22;
    item.bslash     = value_byte == 8'h5C;
    item.zero       = value_byte == 8'h00;
    // fold upper case for the keyword compare
    item.lower      = ((value_byte >= 8'h41) && (value_byte <= 8'h5A)) ?
                      (value_byte | 8'h20) : value_byte;
    item.final_byte = final_byte;
  end

endmodule
`default_nettype wire

[rtl/htc_queue.sv]
`default_nettype none
module htc_queue #(
  parameter int unsigned DEPTH = htc_pkg::QUEUE_DEPTH
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           push,
  input  wire htc_pkg::item_t                 push_item,
  input  wire logic                           pop,
  output htc_pkg::item_t                      head_item,
  output logic                                not_empty,
  output logic                                not_full,
  output logic [$clog2(DEPTH+1)-1:0]          count
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

  htc_pkg::item_t   slot_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;

  assign not_empty = count_r != '0;
  assign not_full  = count_r != FULL_CNT;
  assign count     = count_r;
  assign head_item = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_SLOT) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_SLOT) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule
`default_nettype wire

[rtl/htc_back.sv]
`default_nettype none
module htc_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire htc_pkg::item_t item,
  input  wire logic           item_valid,
  output logic                pop,
  output logic                res_valid,
  input  wire logic           res_ready,
  output logic                res_value_ok,
  output logic                res_chunked_found
);

  localparam logic [3:0] PH_FIRST        = 4'd0;
  localparam logic [3:0] PH_AFTER_COMMA  = 4'd1;
  localparam logic [3:0] PH_CODING       = 4'd2;
  localparam logic [3:0] PH_AFTER_CODING = 4'd3;
  localparam logic [3:0] PH_PARAM_START  = 4'd4;
  localparam logic [3:0] PH_ATTR         = 4'd5;
  localparam logic [3:0] PH_AFTER_ATTR   = 4'd6;
  localparam logic [3:0] PH_VALUE_START  = 4'd7;
  localparam logic [3:0] PH_VALUE_TOKEN  = 4'd8;
  localparam logic [3:0] PH_QUOTED       = 4'd9;
  localparam logic [3:0] PH_ESCAPE       = 4'd10;
  localparam logic [3:0] PH_AFTER_PARAM  = 4'd11;
  localparam logic [3:0] PH_ERROR        = 4'd12;

  logic [3:0] ph_r, ph_nxt;
  logic [2:0] pos_r, pos_nxt;
  logic       still_r, still_nxt;
  logic       seen_r, seen_nxt;
  logic       res_valid_r, res_valid_nxt;
  logic       ok_r, chunked_r;

  logic [3:0] ph_n;
  logic       do_start, do_feed, do_end;
  logic [2:0] pos0, pos_n;
  logic       st0, still_n, hit, seen_n, seen_fin, ok_fin;

  // Shared tail after a coding, value or blank run.
  function automatic logic [3:0] after_item(input htc_pkg::item_t it,
                                            input logic [3:0] stay);
    logic [3:0] ph;
    if (it.blank) begin
      ph = stay;
    end else if (it.semi) begin
      ph = PH_PARAM_START;
    end else if (it.comma) begin
      ph = PH_AFTER_COMMA;
    end else begin
      ph = PH_ERROR;
    end
    return ph;
  endfunction

  assign pop = item_valid && (!res_valid_r || res_ready);

  always_comb begin
    do_start = 1'b0;
    do_feed  = 1'b0;
    do_end   = 1'b0;
    case (ph_r)
      PH_FIRST, PH_AFTER_COMMA: begin
        if (item.tok) begin
          do_start = 1'b1;
          do_feed  = 1'b1;
          ph_n     = PH_CODING;
        end else if ((ph_r == PH_AFTER_COMMA) && item.blank) begin
          ph_n = PH_AFTER_COMMA;
        end else begin
          ph_n = PH_ERROR;
        end
      end
      PH_CODING: begin
        if (item.tok) begin
          do_feed = 1'b1;
          ph_n    = PH_CODING;
        end else begin
          do_end = 1'b1;
          ph_n   = after_item(item, PH_AFTER_CODING);
        end
      end
      PH_AFTER_CODING: ph_n = after_item(item, PH_AFTER_CODING);
      PH_PARAM_START: begin
        if (item.blank) begin
          ph_n = PH_PARAM_START;
        end else begin
          ph_n = item.tok ? PH_ATTR : PH_ERROR;
        end
      end
      PH_ATTR: begin
        if (item.tok) begin
          ph_n = PH_ATTR;
        end else if (item.equals) begin
          ph_n = PH_VALUE_START;
        end else begin
          ph_n = item.blank ? PH_AFTER_ATTR : PH_ERROR;
        end
      end
      PH_AFTER_ATTR: begin
        if (item.equals) begin
          ph_n = PH_VALUE_START;
        end else begin
          ph_n = item.blank ? PH_AFTER_ATTR : PH_ERROR;
        end
      end
      PH_VALUE_START: begin
        if (item.blank) begin
          ph_n = PH_VALUE_START;
        end else if (item.dquote) begin
          ph_n = PH_QUOTED;
        end else begin
          ph_n = item.tok ? PH_VALUE_TOKEN : PH_ERROR;
        end
      end
      PH_VALUE_TOKEN: begin
        ph_n = item.tok ? PH_VALUE_TOKEN : after_item(item, PH_AFTER_PARAM);
      end
      PH_QUOTED: begin
        if (item.zero) begin
          ph_n = PH_ERROR;
        end else if (item.dquote) begin
          ph_n = PH_AFTER_PARAM;
        end else begin
          ph_n = item.bslash ? PH_ESCAPE : PH_QUOTED;
        end
      end
      PH_ESCAPE:      ph_n = item.zero ? PH_ERROR : PH_QUOTED;
      PH_AFTER_PARAM: ph_n = after_item(item, PH_AFTER_PARAM);
      default:        ph_n = PH_ERROR;
    endcase
  end

  // Keyword tracker: advance on a matching letter, drop the match otherwise.
  always_comb begin
    pos0    = do_start ? 3'd0 : pos_r;
    st0     = do_start ? 1'b1 : still_r;
    hit     = st0 && (pos0 != htc_pkg::KEYWORD_LEN) &&
              (item.lower == htc_pkg::keyword_char(pos0));
    pos_n   = pos0;
    still_n = st0;
    if (do_feed) begin
      if (hit) begin
        pos_n = pos0 + 3'd1;
      end else begin
        still_n = 1'b0;
      end
    end
    seen_n   = seen_r || (do_end && still_r && (pos_r == htc_pkg::KEYWORD_LEN));
    seen_fin = seen_n ||
               ((ph_n == PH_CODING) && still_n && (pos_n == htc_pkg::KEYWORD_LEN));
    ok_fin   = (ph_n == PH_CODING) || (ph_n == PH_AFTER_CODING) ||
               (ph_n == PH_VALUE_TOKEN) || (ph_n == PH_AFTER_PARAM);
  end

  always_comb begin
    ph_nxt        = ph_r;
    pos_nxt       = pos_r;
    still_nxt     = still_r;
    seen_nxt      = seen_r;
    res_valid_nxt = res_valid_r && !res_ready;
    if (pop) begin
      if (item.final_byte) begin
        ph_nxt        = PH_FIRST;
        pos_nxt       = 3'd0;
        still_nxt     = 1'b1;
        seen_nxt      = 1'b0;
        res_valid_nxt = 1'b1;
      end else begin
        ph_nxt    = ph_n;
        pos_nxt   = pos_n;
        still_nxt = still_n;
        seen_nxt  = seen_n;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r        <= PH_FIRST;
      pos_r       <= 3'd0;
      still_r     <= 1'b1;
      seen_r      <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      ph_r        <= ph_nxt;
      pos_r       <= pos_nxt;
      still_r     <= still_nxt;
      seen_r      <= seen_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && item.final_byte) begin
      ok_r      <= ok_fin;
      chunked_r <= seen_fin;
    end
  end

  assign res_valid         = res_valid_r;
  assign res_value_ok      = ok_r;
  assign res_chunked_found = chunked_r;

endmodule
`default_nettype wire

[rtl/http_transfer_coding_parser.sv]
`default_nettype none
// Transfer-Encoding value checker. Feed the header value one byte per word
// on the in_ channel, with in_final_byte high on its last byte; for every
// value exactly one word comes out on the out_ channel: out_value_ok says
// whether the value is a well-formed coding list (tokens, optional
// ;attr=value parameters with token or quoted values, spaces and tabs around
// separators but not before the first token), and out_chunked_found says
// whether some coding equals "chunked" in any letter case. A classifier
// tags each byte and pushes it into a small queue; a grammar engine drains
// the queue at one byte per cycle, pausing while an unaccepted result
// waits, and holds the result in an output register. Sustained rate is
// one byte per cycle while out_ready takes each result word; with the
// queue empty, the final byte is first written into the queue, then the
// engine steps on it and sets the registered out_valid.
// The queue, QUEUE_DEPTH words deep, absorbs stalls on the result side.
module http_transfer_coding_parser #(
  parameter int unsigned QUEUE_DEPTH = htc_pkg::QUEUE_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_value_byte,
  input  wire logic       in_final_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            out_value_ok,
  output logic            out_chunked_found
);

  htc_pkg::item_t                    front_item;
  htc_pkg::item_t                    head_item;
  logic                              push;
  logic                              pop;
  logic                              q_not_empty;
  logic                              q_not_full;
  logic [$clog2(QUEUE_DEPTH+1)-1:0]  q_count;

  // Classify the incoming byte combinationally.
  htc_front u_front (
    .value_byte (in_value_byte),
    .final_byte (in_final_byte),
    .item       (front_item)
  );

  // Accept a word whenever the queue has room.
  assign in_ready = q_not_full;
  assign push     = in_valid && q_not_full;

  htc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (front_item),
    .pop       (pop),
    .head_item (head_item),
    .not_empty (q_not_empty),
    .not_full  (q_not_full),
    .count     (q_count)
  );

  // Step the grammar; pop only when the result register can take a word.
  htc_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .item              (head_item),
    .item_valid        (q_not_empty),
    .pop               (pop),
    .res_valid         (out_valid),
    .res_ready         (out_ready),
    .res_value_ok      (out_value_ok),
    .res_chunked_found (out_chunked_found)
  );

`ifndef ASSERT_OFF
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_count <= ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH))
    else $error("queue count exceeds depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_not_empty)
    else $error("pop from empty queue");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && head_item.final_byte) |=> out_valid)
    else $error("final byte popped without a result");

  a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(pop && head_item.final_byte))
    else $error("result raised without a final byte");
`endif

endmodule
`default_nettype wire

[verif/htc_checker.sv]
`default_nettype none
module htc_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_ready,
  input  wire logic [7:0]  in_value_byte,
  input  wire logic        in_final_byte,
  input  wire logic        out_valid,
  input  wire logic        out_ready,
  input  wire logic        out_value_ok,
  input  wire logic        out_chunked_found,
  output int unsigned      fail_count,
  output int unsigned      awaiting
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [3:0] {
    G_FIRST, G_NEXT_CODING, G_CODING, G_CODING_DONE, G_PARAM, G_ATTR, G_ATTR_DONE,
    G_VALUE, G_VALUE_TOKEN, G_QUOTED, G_ESCAPE, G_PARAM_DONE, G_ERROR
  } grammar_phase_t;

  typedef struct packed {
    logic value_ok;
    logic chunked;
  } coding_verdict_t;

  localparam logic [55:0] CHUNKED_TEXT = "chunked";
  localparam logic [2:0]  CHUNKED_LEN  = 3'd7;
  localparam logic [7:0]  NUL_BYTE     = 8'h00;

  grammar_phase_t  phase = G_FIRST;
  logic [2:0]      kw_pos = '0;
  logic            kw_live = 1'b1;
  logic            chunked_seen = 1'b0;
  coding_verdict_t verdicts[$];
  int unsigned     errs = 0;

  function automatic logic is_token(input logic [7:0] c);
    if (c < 8'h21 || c > 8'h7E) return 1'b0;
    case (c)
      "(", ")", "<", ">", "@", ",", ";", ":", "\\", "\"",
      "/", "[", "]", "?", "=", "{", "}": return 1'b0;
      default: return 1'b1;
    endcase
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return c == " " || c == "\t";
  endfunction

  // Shared exit from a coding, a parameter value or the blanks after them.
  function automatic grammar_phase_t after_field(input logic [7:0] c,
                                                 input grammar_phase_t stay);
    if (is_blank(c)) return stay;
    if (c == ";") return G_PARAM;
    if (c == ",") return G_NEXT_CODING;
    return G_ERROR;
  endfunction

  task automatic reset_parser();
    phase = G_FIRST;
    kw_pos = '0;
    kw_live = 1'b1;
    chunked_seen = 1'b0;
  endtask

  task automatic feed_keyword(input logic [7:0] c);
    logic [7:0] low;
    int idx;
    low = (c >= "A" && c <= "Z") ? c + 8'h20 : c;
    idx = 6 - int'(kw_pos);
    if (kw_live && kw_pos < CHUNKED_LEN && low == CHUNKED_TEXT[8*idx +: 8]) begin
      kw_pos = kw_pos + 3'd1;
    end else begin
      kw_live = 1'b0;
    end
  endtask

  task automatic close_keyword();
    if (kw_live && kw_pos == CHUNKED_LEN) chunked_seen = 1'b1;
  endtask

  task automatic absorb_byte(input logic [7:0] c, input logic last);
    logic tok;
    logic ok;
    tok = is_token(c);
    case (phase)
      G_FIRST, G_NEXT_CODING: begin
        if (tok) begin
          kw_pos = '0;
          kw_live = 1'b1;
          feed_keyword(c);
          phase = G_CODING;
        end else if (!(phase == G_NEXT_CODING && is_blank(c))) begin
          phase = G_ERROR;
        end
      end
      G_CODING: begin
        if (tok) begin
          feed_keyword(c);
        end else begin
          close_keyword();
          phase = after_field(c, G_CODING_DONE);
        end
      end
      G_CODING_DONE: phase = after_field(c, G_CODING_DONE);
      G_PARAM: begin
        if (!is_blank(c)) phase = tok ? G_ATTR : G_ERROR;
      end
      G_ATTR: begin
        if (c == "=") phase = G_VALUE;
        else if (!tok) phase = is_blank(c) ? G_ATTR_DONE : G_ERROR;
      end
      G_ATTR_DONE: begin
        if (c == "=") phase = G_VALUE;
        else if (!is_blank(c)) phase = G_ERROR;
      end
      G_VALUE: begin
        if (c == "\"") phase = G_QUOTED;
        else if (!is_blank(c)) phase = tok ? G_VALUE_TOKEN : G_ERROR;
      end
      G_VALUE_TOKEN: begin
        if (!tok) phase = after_field(c, G_PARAM_DONE);
      end
      G_QUOTED: begin
        if (c == NUL_BYTE) phase = G_ERROR;
        else if (c == "\"") phase = G_PARAM_DONE;
        else if (c == "\\") phase = G_ESCAPE;
      end
      G_ESCAPE: phase = (c == NUL_BYTE) ? G_ERROR : G_QUOTED;
      G_PARAM_DONE: phase = after_field(c, G_PARAM_DONE);
      default: phase = G_ERROR;
    endcase
    if (last) begin
      if (phase == G_CODING) close_keyword();
      ok = phase == G_CODING || phase == G_CODING_DONE ||
           phase == G_VALUE_TOKEN || phase == G_PARAM_DONE;
      verdicts.push_back('{value_ok: ok, chunked: chunked_seen});
      reset_parser();
    end
  endtask

  task automatic report_mismatch(input string what);
    $display("%0t ns: result word wrong: %s", $time, what);
    errs++;
  endtask

  always @(posedge clk) begin
    coding_verdict_t want;
    if (!rst_n) begin
      reset_parser();
      verdicts.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (verdicts.size() == 0) begin
          report_mismatch("no value pending");
        end else begin
          want = verdicts.pop_front();
          if (out_value_ok !== want.value_ok)
            report_mismatch($sformatf("value_ok %b, want %b", out_value_ok, want.value_ok));
          if (out_chunked_found !== want.chunked)
            report_mismatch($sformatf("chunked_found %b, want %b",
                                      out_chunked_found, want.chunked));
        end
      end
      if (in_valid && in_ready) absorb_byte(in_value_byte, in_final_byte);
    end
    awaiting <= verdicts.size();
    fail_count <= errs;
  end

endmodule
`default_nettype wire

[verif/tb.sv]
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [7:0] text_q_t[$];

  // Random byte budget, split over the three idling phases.
  localparam int unsigned RANDOM_BYTES = 800;
  // Receiver hold-off long enough to fill the byte queue and stall the input.
  localparam int unsigned HOLD_CYCLES  = 300;
  // Cycles without any handshake before the run is declared hung.
  localparam int unsigned STALL_LIMIT  = 4000;
  // Settling time after the last result word; leave ample slack.
  localparam int unsigned DRAIN_CYCLES = 20;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic [7:0] in_value_byte = 8'h00;
  logic       in_final_byte = 1'b0;
  logic       out_ready = 1'b0;
  logic       in_ready;
  logic       out_valid;
  logic       out_value_ok;
  logic       out_chunked_found;

  int unsigned mismatch_count;
  int unsigned values_open;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  bit          hold_pending = 1'b0;
  int unsigned random_sent = 0;
  int unsigned quiet_cycles = 0;

  // Token bytes used when building well-formed values.
  string   token_chars = "!#$%&'*+-.^_|~0123456789abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ";
  text_q_t draft;

  always #10 clk = ~clk;

  http_transfer_coding_parser u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_value_byte     (in_value_byte),
    .in_final_byte     (in_final_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_value_ok      (out_value_ok),
    .out_chunked_found (out_chunked_found)
  );

  htc_checker u_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_value_byte     (in_value_byte),
    .in_final_byte     (in_final_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_value_ok      (out_value_ok),
    .out_chunked_found (out_chunked_found),
    .fail_count        (mismatch_count),
    .awaiting          (values_open)
  );

  // Result side: stall at the current rate; on request, hold ready low for a
  // long stretch so the queue fills and in_ready drops.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_pending) begin
        hold_pending = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog: count cycles in which neither channel moves a word.
  initial begin
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("Mismatches found");
    $finish;
  end

  // Offer one byte; idle first at the sender's rate, then hold the word
  // until the edge that takes it.
  task automatic send_byte(input logic [7:0] b, input logic last);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_value_byte <= b;
    in_final_byte <= last;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stream the draft as one header value, final mark on its last byte.
  task automatic send_draft();
    for (int i = 0; i < draft.size(); i++) send_byte(draft[i], i == draft.size() - 1);
  endtask

  function automatic void push_text(input string s);
    for (int i = 0; i < s.len(); i++) draft.push_back(s[i]);
  endfunction

  // Mostly none, sometimes one or two spaces or tabs.
  function automatic void add_blanks();
    if ($urandom_range(3) == 0) begin
      repeat ($urandom_range(1, 2)) draft.push_back($urandom_range(1) ? " " : "\t");
    end
  endfunction

  // Plain token, or for codings often a case-scrambled "chunked", a prefix of
  // it, or "chunked" with a trailing token byte (exact match only counts).
  function automatic void add_token(input bit as_coding);
    string      kw;
    int         sel;
    int         len;
    logic [7:0] ch;
    kw = "chunked";
    sel = $urandom_range(5);
    if (as_coding && sel < 4) begin
      len = (sel == 2) ? $urandom_range(1, 6) : 7;
      for (int i = 0; i < len; i++) begin
        ch = kw[i];
        if ($urandom_range(1)) ch = ch - 8'h20;
        draft.push_back(ch);
      end
      if (sel == 3) draft.push_back(token_chars[$urandom_range(token_chars.len() - 1)]);
    end else begin
      repeat ($urandom_range(1, 5)) draft.push_back(token_chars[$urandom_range(token_chars.len() - 1)]);
    end
  endfunction

  // Quoted value with arbitrary nonzero text and backslash escapes.
  function automatic void add_quoted();
    logic [7:0] ch;
    draft.push_back("\"");
    repeat ($urandom_range(0, 4)) begin
      if ($urandom_range(9) == 0) begin
        draft.push_back("\\");
        draft.push_back(8'($urandom_range(1, 255)));
      end else begin
        ch = 8'($urandom_range(1, 255));
        if (ch == "\"" || ch == "\\") ch = "q";
        draft.push_back(ch);
      end
    end
    draft.push_back("\"");
  endfunction

  // Build a well-formed coding list, then maybe break it.
  function automatic void build_value();
    int pick;
    int keep;
    draft.delete();
    for (int c = 0; c < $urandom_range(1, 3); c++) begin
      if (c > 0) begin
        add_blanks();
        draft.push_back(",");
        add_blanks();
      end
      add_token(1'b1);
      repeat ($urandom_range(2) == 0 ? $urandom_range(1, 2) : 0) begin
        add_blanks();
        draft.push_back(";");
        add_blanks();
        add_token(1'b0);
        add_blanks();
        draft.push_back("=");
        add_blanks();
        if ($urandom_range(1)) add_quoted();
        else add_token(1'b0);
      end
    end
    add_blanks();
    pick = $urandom_range(99);
    if (pick < 70) begin
      // keep it well formed
    end else if (pick < 80) begin
      draft[$urandom_range(draft.size() - 1)] = 8'($urandom_range(255));
    end else if (pick < 88) begin
      keep = $urandom_range(1, draft.size());
      while (draft.size() > keep) void'(draft.pop_back());
    end else if (pick < 93) begin
      draft.push_front($urandom_range(1) ? " " : "\t");
    end else begin
      // pure noise: any byte, zero and high bytes included
      draft.delete();
      repeat ($urandom_range(1, 6)) draft.push_back(8'($urandom_range(255)));
    end
  endfunction

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 16;
    recv_idle_pct = 55;

    // Directed: exact keyword in mixed case.
    draft.delete(); push_text("cHUNKED"); send_draft();
    // Leading blank.
    draft.delete(); push_text(" a"); send_draft();
    // Lone zero byte.
    draft.delete(); draft.push_back(8'h00); send_draft();
    // Highest token byte alone.
    draft.delete(); push_text("~"); send_draft();
    // Coding ended by an offending byte still counts as chunked.
    draft.delete(); push_text("chunked@"); send_draft();
    // High byte inside quotes, value cut after a backslash.
    draft.delete(); push_text("a;b=\""); draft.push_back(8'hFF); push_text("\\"); send_draft();
    // Value cut after a comma.
    draft.delete(); push_text("x,"); send_draft();

    // Random: three idling phases, a long receiver hold at the start of the
    // last one while the sender keeps pushing.
    for (int ph = 0; ph < 3; ph++) begin
      if (ph == 1) begin
        send_idle_pct = 55;
        recv_idle_pct = 16;
      end else if (ph == 2) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_pending = 1'b1;
      end
      while (random_sent < (ph + 1) * RANDOM_BYTES / 3) begin
        build_value();
        send_draft();
        random_sent += draft.size();
      end
    end
    in_valid <= 1'b0;

    // Let the checker see the last word, then drain.
    @(posedge clk);
    while (values_open != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
`default_nettype wire

[files.f]
rtl/htc_pkg.sv
rtl/htc_front.sv
rtl/htc_queue.sv
rtl/htc_back.sv
rtl/http_transfer_coding_parser.sv
verif/htc_checker.sv
verif/tb.sv
